// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime tester.
// No dependencies; used by tdpt_ctrl, tdpt_datapath and the top level.
package tdpt_pkg;

  localparam int DEFAULT_WIDTH = 32;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture candidate, divisor = 3, square = 9
    logic div_start;  // clear remainder, point at the top bit
    logic div_step;   // one restoring remainder step
    logic advance;    // divisor += 2, square updated to match
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lt2;        // candidate below two
    logic is2;        // candidate equals two
    logic even;       // candidate is even
    logic bound_ok;   // divisor squared does not exceed candidate
    logic div_last;   // the step in progress handles bit 0
    logic rem_zero;   // remainder is zero
  } status_t;

endpackage

// ===== rtl/tdpt_datapath.sv =====
// Datapath of the prime tester: candidate, trial divisor, running square
// and a bit-serial restoring remainder unit. Depends on tdpt_pkg.
module tdpt_datapath #(
  parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   candidate,
  input  tdpt_pkg::cmd_t     cmd,
  output tdpt_pkg::status_t  status
);

  localparam int IDX_W = $clog2(WIDTH);
  localparam int SQ_W  = WIDTH + 2;

  logic [WIDTH-1:0] n_r,   n_nxt;
  logic [WIDTH-1:0] d_r,   d_nxt;
  logic [SQ_W-1:0]  sq_r,  sq_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   d_ext;
  logic [WIDTH:0]   diff;

  assign shifted = {rem_r, n_r[idx_r]};
  assign d_ext   = {1'b0, d_r};
  assign diff    = shifted - d_ext;

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      n_nxt  = candidate;
      d_nxt  = WIDTH'(3);
      sq_nxt = SQ_W'(9);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      idx_nxt = IDX_W'(WIDTH - 1);
    end
    if (cmd.div_step) begin
      // restore when the shifted remainder is below the divisor
      rem_nxt = (shifted >= d_ext) ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      idx_nxt = idx_r - IDX_W'(1);
    end
    if (cmd.advance) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_nxt  = d_r + WIDTH'(2);
      sq_nxt = sq_r + {d_r, 2'b00} + SQ_W'(4);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
  end

  always_comb begin
    status.lt2      = (n_r[WIDTH-1:1] == '0);
    status.is2      = (n_r == WIDTH'(2));
    status.even     = ~n_r[0];
    status.bound_ok = (sq_r <= {2'b00, n_r});
    status.div_last = (idx_r == '0);
    status.rem_zero = (rem_r == '0);
  end

endmodule

// ===== rtl/tdpt_ctrl.sv =====
// Sequencer of the prime tester: handshakes, special cases, divisor loop.
// Depends on tdpt_pkg; drives tdpt_datapath through cmd_t / status_t.
module tdpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_prime,
  input  tdpt_pkg::status_t  status,
  output tdpt_pkg::cmd_t     cmd
);

  tdpt_pkg::state_t state_r, state_nxt;
  logic             res_r,   res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_CHECK: begin
        if (status.lt2) begin
          res_nxt   = 1'b0;
          state_nxt = tdpt_pkg::ST_DONE;
        end else if (status.is2) begin
          res_nxt   = 1'b1;
          state_nxt = tdpt_pkg::ST_DONE;
        end else if (status.even) begin
          res_nxt   = 1'b0;
          state_nxt = tdpt_pkg::ST_DONE;
        end else if (!status.bound_ok) begin
          res_nxt   = 1'b1;
          state_nxt = tdpt_pkg::ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = tdpt_pkg::ST_DIVIDE;
        end
      end
      tdpt_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = tdpt_pkg::ST_TEST;
        end
      end
      tdpt_pkg::ST_TEST: begin
        if (status.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = tdpt_pkg::ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    res_r <= res_nxt;
  end

  assign in_ready     = (state_r == tdpt_pkg::ST_IDLE);
  assign out_valid    = (state_r == tdpt_pkg::ST_DONE);
  assign out_is_prime = res_r;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath.

// Takes one WIDTH-bit unsigned candidate word and returns one word with
// is_prime set when the candidate is prime. Zero and one are not prime, two
// is prime, other even values are not prime. Odd candidates are divided by
// 3, 5, 7, ... for as long as the divisor squared does not exceed the
// candidate; the first zero remainder answers "not prime". The single
// bit-serial remainder unit sets the pace: each trial divisor costs one
// bound check, WIDTH remainder steps and one test. Prime candidates end
// with one last bound check that fails. At most about sqrt(n) / 2 trial
// divisors are tried for a candidate n. Even values, values below two and
// primes below nine are settled in the first check, with no division.
// The result must be taken before the next candidate word is accepted:
// one word is in flight at a time.
module trial_division_prime_test #(
  parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // candidate channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_candidate,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_prime
);

  tdpt_pkg::cmd_t    cmd;
  tdpt_pkg::status_t status;

  // Sequencer: hold the result word until taken, advance the divisor loop
  tdpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime),
    .status       (status),
    .cmd          (cmd)
  );

  // Candidate, divisor, running square and serial remainder
  tdpt_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .candidate (in_candidate),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
